[rtl/stq_pkg.sv]
// Package for the segment tree range query core.
// Field types, operation and combine codes, register map constants.
// Used by the channel interfaces and the core; no dependencies.
package stq_pkg;

  localparam int IDX_BITS  = 10;
  localparam int WORD_BITS = 32;
  localparam int APB_AW    = 3;
  localparam int APB_DW    = 32;

  // Register index sits at paddr[REG_IDX_LSB] (one 32-bit word each)
  localparam int REG_IDX_LSB = 2;

  typedef logic [IDX_BITS-1:0]         index_t;
  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic                        op_t;
  typedef logic [1:0]                  mode_t;
  typedef logic                        reg_idx_t;

  // Operations carried by a request beat
  localparam op_t OP_UPDATE = 1'b0;
  localparam op_t OP_QUERY  = 1'b1;

  // Combine operators; the unused code behaves as maximum
  localparam mode_t MODE_MAX = 2'd0;
  localparam mode_t MODE_MIN = 2'd1;
  localparam mode_t MODE_SUM = 2'd2;

  // Configuration registers
  localparam reg_idx_t REG_MODE  = 1'b0;
  localparam reg_idx_t REG_IDENT = 1'b1;

endpackage

[rtl/stq_if.sv]
// Valid/ready channel interfaces for the segment tree range query core.
// stq_req_if carries update and query requests, stq_rsp_if query results.
// Depends on stq_pkg for the field types.
interface stq_req_if;
  import stq_pkg::*;

  logic   valid;
  logic   ready;
  op_t    operation;
  index_t leaf_index;
  word_t  new_value;
  index_t range_first;
  index_t range_last;

  modport source (
    output valid, operation, leaf_index, new_value, range_first, range_last,
    input  ready
  );
  modport sink (
    input  valid, operation, leaf_index, new_value, range_first, range_last,
    output ready
  );
endinterface

interface stq_rsp_if;
  import stq_pkg::*;

  logic  valid;
  logic  ready;
  word_t query_result;

  modport source (
    output valid, query_result,
    input  ready
  );
  modport sink (
    input  valid, query_result,
    output ready
  );
endinterface

[rtl/segment_tree_range_query_core.sv]
// Segment tree over LEAVES values with point update and range query.
// Uses stq_pkg and the channel interfaces in stq_if.sv.
//
// Usage:
//   req  - request beats: operation selects an update (write new_value to
//          leaf leaf_index) or a query over leaves [range_first, range_last],
//          the upper bound clamped to LEAVES-1. Updates to a leaf at or above
//          LEAVES are dropped.
//   rsp  - one result beat per query, none per update: the combination over
//          the range (maximum, minimum or wrapping sum), or identity_value
//          when the range is empty.
//   APB  - combine_mode at 0x0, identity_value at 0x4; write only while idle.
// Timing: req.ready is high only while idle. An update accepts and writes the
//   leaf, then recomputes its ancestors in turn, at most log2(SPAN) of them
//   (10 at the default size); the walk stops at the first ancestor that keeps
//   its value. A query walks the tree one child node per cycle through a single
//   combine unit and one memory read port; an empty or fully covered range
//   skips the walk. A finished result waits in the output register; a stalled
//   receiver blocks the core only when the next query result is ready.
// Reset: rst clears the control and configuration registers to zero and then
//   sweeps all 2*SPAN-1 nodes of memory to zero, one node per cycle, with
//   req.ready low. Configuration writes are taken during the sweep.
module segment_tree_range_query_core #(
  parameter int LEAVES     = 1024,
  parameter int VALUE_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [stq_pkg::APB_AW-1:0]  paddr,
  input  logic [stq_pkg::APB_DW-1:0]  pwdata,
  output logic [stq_pkg::APB_DW-1:0]  prdata,
  output logic                        pready,
  stq_req_if.sink                     req,
  stq_rsp_if.source                   rsp
);
  import stq_pkg::*;

  localparam int LW    = $clog2(LEAVES);
  localparam int SPAN  = 1 << LW;
  localparam int AW    = LW + 1;
  localparam int NODES = 2 * SPAN - 1;
  localparam int IW    = (LW > IDX_BITS) ? LW : IDX_BITS;
  localparam int VB    = VALUE_BITS;

  typedef logic signed [VB-1:0] val_t;
  typedef logic [AW-1:0]        node_t;
  typedef logic [LW-1:0]        pos_t;
  typedef logic [IW-1:0]        bnd_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPD,
    ST_QWALK,
    ST_QFIN
  } state_t;

  function automatic node_t sibling_f(input node_t n);
    return n[0] ? node_t'(n + node_t'(1)) : node_t'(n - node_t'(1));
  endfunction

  function automatic node_t parent_f(input node_t n);
    return node_t'((n - node_t'(1)) >> 1);
  endfunction

  function automatic val_t combine_f(input mode_t m, input val_t a, input val_t b);
    val_t y;
    unique case (m)
      MODE_MIN: y = (a < b) ? a : b;
      MODE_SUM: y = val_t'(a + b);
      default:  y = (a < b) ? b : a;
    endcase
    return y;
  endfunction

  state_t   state;
  node_t    clr_addr;
  mode_t    mode;
  val_t     ident;

  // Node memory, two registered read ports and one write port
  val_t     mem [NODES];
  val_t     rd_a;
  val_t     rd_b;
  node_t    ra_a;
  node_t    ra_b;
  logic     we;
  node_t    wa;
  val_t     wd;

  // Update walk
  node_t    u_chd;
  val_t     u_val;
  node_t    u_par;
  logic     u_change;

  // Query walk: up to two partially covered nodes per level
  bnd_t     q_first;
  bnd_t     q_last;
  logic [1:0] cur_vld;
  node_t    cur_node [2];
  pos_t     cur_lo   [2];
  pos_t     cur_hi   [2];
  logic [1:0] nxt_vld;
  node_t    nxt_node [2];
  pos_t     nxt_lo   [2];
  pos_t     nxt_hi   [2];
  logic [1:0] nxt_vld_next;
  node_t    nxt_node_next [2];
  pos_t     nxt_lo_next   [2];
  pos_t     nxt_hi_next   [2];
  logic     step_slot;
  logic     step_child;

  // Combine stage and accumulator
  logic     s1_valid;
  logic     s1_mem;
  val_t     acc;
  logic     acc_valid;

  logic     rsp_valid;
  word_t    rsp_data;

  // Shared combine unit
  val_t     comb_a;
  val_t     comb_b;
  val_t     comb_y;

  // Request decode
  logic     in_take;
  val_t     in_val;
  bnd_t     in_last_c;
  logic     in_leaf_ok;
  node_t    in_leaf;
  logic     in_empty;
  logic     in_root_cov;

  // Walk step decode
  node_t    w_node;
  pos_t     w_lo;
  pos_t     w_hi;
  pos_t     w_mid;
  node_t    c_node;
  pos_t     c_lo;
  pos_t     c_hi;
  logic     c_cov;
  logic     c_out;
  logic     c_part;
  logic     walk_last;
  logic     cfg_wr;
  reg_idx_t reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[REG_IDX_LSB];
  assign cfg_wr  = psel && penable && pwrite;
  assign prdata  = (reg_sel == REG_MODE) ? APB_DW'(mode) : APB_DW'(ident);

  assign req.ready        = (state == ST_IDLE);
  assign rsp.valid        = rsp_valid;
  assign rsp.query_result = rsp_data;

  // Decode the request beat
  always_comb begin
    in_take     = req.valid && req.ready;
    in_val      = val_t'(req.new_value);
    in_last_c   = (bnd_t'(req.range_last) > bnd_t'(LEAVES - 1)) ?
                  bnd_t'(LEAVES - 1) : bnd_t'(req.range_last);
    in_leaf_ok  = bnd_t'(req.leaf_index) <= bnd_t'(LEAVES - 1);
    in_leaf     = node_t'(SPAN - 1) + node_t'(req.leaf_index);
    in_empty    = bnd_t'(req.range_first) > in_last_c;
    in_root_cov = (req.range_first == '0) && (in_last_c == bnd_t'(SPAN - 1));
  end

  // Classify the current child node against the query range
  always_comb begin
    w_node    = cur_node[step_slot];
    w_lo      = cur_lo[step_slot];
    w_hi      = cur_hi[step_slot];
    w_mid     = pos_t'(({1'b0, w_lo} + {1'b0, w_hi}) >> 1);
    c_node    = {w_node[AW-2:0], 1'b1} + node_t'(step_child);
    c_lo      = step_child ? pos_t'(w_mid + pos_t'(1)) : w_lo;
    c_hi      = step_child ? w_hi : w_mid;
    c_cov     = (q_first <= bnd_t'(c_lo)) && (bnd_t'(c_hi) <= q_last);
    c_out     = (q_last < bnd_t'(c_lo)) || (bnd_t'(c_hi) < q_first);
    c_part    = !c_cov && !c_out;
    walk_last = step_child && (step_slot || !cur_vld[1]);
  end

  // Queue a partially covered child for the next level
  always_comb begin
    nxt_vld_next  = nxt_vld;
    nxt_node_next = nxt_node;
    nxt_lo_next   = nxt_lo;
    nxt_hi_next   = nxt_hi;
    if (state == ST_QWALK && c_part) begin
      nxt_vld_next[nxt_vld[0]]  = 1'b1;
      nxt_node_next[nxt_vld[0]] = c_node;
      nxt_lo_next[nxt_vld[0]]   = c_lo;
      nxt_hi_next[nxt_vld[0]]   = c_hi;
    end
  end

  // Route operands into the combine unit
  always_comb begin
    u_par = parent_f(u_chd);
    if (state == ST_UPD) begin
      comb_a = u_chd[0] ? u_val : rd_a;
      comb_b = u_chd[0] ? rd_a : u_val;
    end else begin
      comb_a = acc;
      comb_b = s1_mem ? rd_a : ident;
    end
    comb_y   = combine_f(mode, comb_a, comb_b);
    u_change = (comb_y != rd_b);
  end

  // Memory addresses and write port
  always_comb begin
    we   = 1'b0;
    wa   = clr_addr;
    wd   = '0;
    ra_a = '0;
    ra_b = '0;
    unique case (state)
      ST_CLEAR: begin
        we = 1'b1;
      end
      ST_IDLE: begin
        ra_a = (req.operation == OP_QUERY) ? '0 : sibling_f(in_leaf);
        ra_b = parent_f(in_leaf);
        if (in_take && req.operation == OP_UPDATE && in_leaf_ok) begin
          we = 1'b1;
          wa = in_leaf;
          wd = in_val;
        end
      end
      ST_UPD: begin
        ra_a = sibling_f(u_par);
        ra_b = parent_f(u_par);
        we   = u_change;
        wa   = u_par;
        wd   = comb_y;
      end
      ST_QWALK: begin
        ra_a = c_node;
      end
      ST_QFIN: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_a <= mem[ra_a];
    rd_b <= mem[ra_b];
  end

  // Sequencer, configuration registers and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_addr   <= '0;
      mode       <= MODE_MAX;
      ident      <= '0;
      cur_vld    <= '0;
      nxt_vld    <= '0;
      step_slot  <= 1'b0;
      step_child <= 1'b0;
      s1_valid   <= 1'b0;
      s1_mem     <= 1'b0;
      acc_valid  <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      // Register writes
      if (cfg_wr) begin
        unique case (reg_sel)
          REG_MODE:  mode  <= pwdata[1:0];
          REG_IDENT: ident <= val_t'($signed(pwdata));
        endcase
      end

      // Fold the staged value into the accumulator
      if (s1_valid) begin
        acc       <= acc_valid ? comb_y : comb_b;
        acc_valid <= 1'b1;
      end

      // Stage a fully covered root or a settled child for the fold
      s1_valid <= (state == ST_QWALK && !c_part) ||
                  (state == ST_IDLE && in_take && req.operation == OP_QUERY &&
                   !in_empty && in_root_cov);

      // Drop the result once the beat is taken, unless a new one loads
      if (rsp_valid && rsp.ready && !(state == ST_QFIN && !s1_valid)) begin
        rsp_valid <= 1'b0;
      end

      unique case (state)
        ST_CLEAR: begin
          clr_addr <= node_t'(clr_addr + node_t'(1));
          if (clr_addr == node_t'(NODES - 1)) begin
            state <= ST_IDLE;
          end
        end

        ST_IDLE: begin
          if (in_take) begin
            if (req.operation == OP_UPDATE) begin
              if (in_leaf_ok) begin
                u_chd <= in_leaf;
                u_val <= in_val;
                state <= ST_UPD;
              end
            end else begin
              q_first   <= bnd_t'(req.range_first);
              q_last    <= in_last_c;
              acc_valid <= in_empty;
              if (in_empty) begin
                acc       <= ident;
                state     <= ST_QFIN;
              end else if (in_root_cov) begin
                s1_mem   <= 1'b1;
                state    <= ST_QFIN;
              end else begin
                cur_vld     <= 2'b01;
                cur_node[0] <= '0;
                cur_lo[0]   <= '0;
                cur_hi[0]   <= pos_t'(SPAN - 1);
                nxt_vld     <= '0;
                step_slot   <= 1'b0;
                step_child  <= 1'b0;
                state       <= ST_QWALK;
              end
            end
          end
        end

        // Climb while the recomputed ancestor changes
        ST_UPD: begin
          if (u_change && u_par != '0) begin
            u_chd <= u_par;
            u_val <= comb_y;
          end else begin
            state <= ST_IDLE;
          end
        end

        // One child node per cycle, level by level
        ST_QWALK: begin
          if (!c_part) begin
            s1_mem   <= c_cov;
          end
          if (walk_last) begin
            cur_vld    <= nxt_vld_next;
            cur_node   <= nxt_node_next;
            cur_lo     <= nxt_lo_next;
            cur_hi     <= nxt_hi_next;
            nxt_vld    <= '0;
            step_slot  <= 1'b0;
            step_child <= 1'b0;
            if (nxt_vld_next == '0) begin
              state <= ST_QFIN;
            end
          end else begin
            nxt_vld  <= nxt_vld_next;
            nxt_node <= nxt_node_next;
            nxt_lo   <= nxt_lo_next;
            nxt_hi   <= nxt_hi_next;
            if (!step_child) begin
              step_child <= 1'b1;
            end else begin
              step_slot  <= 1'b1;
              step_child <= 1'b0;
            end
          end
        end

        // Hand the result over once the last value is folded in
        ST_QFIN: begin
          if (!s1_valid && (!rsp_valid || rsp.ready)) begin
            rsp_valid <= 1'b1;
            rsp_data  <= word_t'(acc);
            state     <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // A level never holds more than two partially covered nodes
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    (state == ST_QWALK && c_part && nxt_vld[0]) |-> !nxt_vld[1])
    else $error("partial node queue overflow");

  // The walk always has a node in the first slot
  a_walk_slot: assert property (@(posedge clk) disable iff (rst)
    (state == ST_QWALK) |-> cur_vld[0])
    else $error("query walk without a current node");

  // A result is never handed over from an empty accumulator
  a_fin_acc: assert property (@(posedge clk) disable iff (rst)
    (state == ST_QFIN && !s1_valid) |-> acc_valid)
    else $error("query finished with no value folded");

  // An update never produces a result beat
  a_upd_silent: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready && req.operation == OP_UPDATE) |=> !$rose(rsp.valid))
    else $error("result beat raised after an update");

endmodule
